// ===== sv/ehd_pkg.sv =====
// Shared types, holiday codes and the day-offset table for the holy-day date block.
`default_nettype none

package ehd_pkg;

  // Holiday codes in output order
  localparam logic [2:0] HOL_EASTER      = 3'd0;
  localparam logic [2:0] HOL_CARNIVAL    = 3'd1;
  localparam logic [2:0] HOL_GOOD_FRIDAY = 3'd2;
  localparam logic [2:0] HOL_WHITSUN     = 3'd3;
  localparam logic [2:0] HOL_ASCENSION   = 3'd4;

  // Easter as a zero-based day of year plus the leap flag of that year
  typedef struct packed {
    logic [6:0] doy;
    logic       leap;
  } easter_t;

  // Day offset of each holiday from Easter Sunday
  function automatic logic signed [7:0] hol_shift(input logic [2:0] hol);
    logic signed [7:0] s;
    unique case (hol)
      HOL_EASTER:      s = 8'sd0;
      HOL_CARNIVAL:    s = -8'sd49;
      HOL_GOOD_FRIDAY: s = -8'sd2;
      HOL_WHITSUN:     s = 8'sd49;
      HOL_ASCENSION:   s = 8'sd39;
      default:         s = 8'sd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ehd_computus.sv =====
// Nine-stage pipeline computing the Gregorian Easter day of year from a year.
`default_nettype none

module ehd_computus (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [15:0]     year,
  output logic                 busy,
  output logic                 out_valid,
  input  wire logic            out_take,
  output ehd_pkg::easter_t     out_date
);
  import ehd_pkg::*;

  localparam int unsigned NSTAGE = 9;

  logic [NSTAGE-1:0] v;
  logic [NSTAGE-1:0] en;

  // Stage enables: a stage loads when empty or when its content moves on
  always_comb begin
    en[NSTAGE-1] = !v[NSTAGE-1] || out_take;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign busy      = !en[0];
  assign out_valid = v[NSTAGE-1];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= start;
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // Stage 1: y/100 and y/19 by reciprocal multiply (exact for 16-bit y)
  logic [15:0] y1;
  logic [9:0]  b1;
  logic [11:0] q19_1;
  logic [32:0] p100;
  logic [31:0] p19;
  assign p100 = 33'(year) * 33'd83887;
  assign p19  = 32'(year) * 32'd55189;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      y1    <= year;
      b1    <= p100[32:23];
      q19_1 <= p19[31:20];
    end
  end

  // Stage 2: remainders a = y%19, c = y%100, and f = (b+8)/25
  logic [4:0]  a2;
  logic [9:0]  b2;
  logic [6:0]  c2;
  logic [4:0]  f2;
  logic [1:0]  yl2;
  logic [15:0] a_full, c_full;
  logic [19:0] pf;
  assign a_full = y1 - 16'(q19_1) * 16'd19;
  assign c_full = y1 - 16'(b1) * 16'd100;
  assign pf     = 20'(b1 + 10'd8) * 20'd656;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      a2  <= a_full[4:0];
      b2  <= b1;
      c2  <= c_full[6:0];
      f2  <= pf[18:14];
      yl2 <= y1[1:0];
    end
  end

  // Stage 3: g = (b-f+1)/3, split b and c, leap-year flag
  logic [4:0] a3;
  logic [9:0] b3;
  logic [7:0] d3, g3;
  logic [1:0] e3, k3;
  logic [4:0] i3;
  logic       leap3;
  logic [19:0] pg;
  assign pg = 20'(b2 - 10'(f2) + 10'd1) * 20'd683;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      a3    <= a2;
      b3    <= b2;
      d3    <= b2[9:2];
      g3    <= pg[18:11];
      e3    <= b2[1:0];
      i3    <= c2[6:2];
      k3    <= c2[1:0];
      leap3 <= (yl2 == 2'd0) && ((c2 != 7'd0) || (b2[1:0] == 2'd0));
    end
  end

  // Stage 4: sum feeding h
  logic [9:0] hsum4;
  logic [4:0] a4, i4;
  logic [1:0] e4, k4;
  logic       leap4;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      hsum4 <= 10'(a3) * 10'd19 + b3 - 10'(d3) - 10'(g3) + 10'd15;
      a4    <= a3;
      e4    <= e3;
      i4    <= i3;
      k4    <= k3;
      leap4 <= leap3;
    end
  end

  // Stage 5: quotient of hsum by 30
  logic [9:0]  hsum5;
  logic [5:0]  hq5;
  logic [4:0]  a5, i5;
  logic [1:0]  e5, k5;
  logic        leap5;
  logic [20:0] ph;
  assign ph = 21'(hsum4) * 21'd1093;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      hsum5 <= hsum4;
      hq5   <= ph[20:15];
      a5    <= a4;
      e5    <= e4;
      i5    <= i4;
      k5    <= k4;
      leap5 <= leap4;
    end
  end

  // Stage 6: h = hsum % 30, sum feeding l
  logic [4:0] h6, a6;
  logic [6:0] lsum6;
  logic       leap6;
  logic [9:0] h_full;
  assign h_full = hsum5 - 10'(hq5) * 10'd30;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      h6    <= h_full[4:0];
      lsum6 <= 7'd46 + {4'd0, e5, 1'b0} + {1'b0, i5, 1'b0} - {2'd0, h_full[4:0]}
               - {5'd0, k5};
      a6    <= a5;
      leap6 <= leap5;
    end
  end

  // Stage 7: quotient of lsum by 7
  logic [6:0]  lsum7;
  logic [3:0]  lq7;
  logic [4:0]  h7, a7;
  logic        leap7;
  logic [14:0] pl;
  assign pl = 15'(lsum6) * 15'd147;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      lsum7 <= lsum6;
      lq7   <= pl[13:10];
      h7    <= h6;
      a7    <= a6;
      leap7 <= leap6;
    end
  end

  // Stage 8: l = lsum % 7, m, packed Easter date month*31 + day-1
  logic [7:0] base8;
  logic       leap8;
  logic [6:0] l_full;
  logic [2:0] l7;
  logic [8:0] msum;
  logic       m7;
  assign l_full = lsum7 - 7'(lq7) * 7'd7;
  assign l7     = l_full[2:0];
  assign msum   = 9'(a7) + 9'(h7) * 9'd11 + 9'(l7) * 9'd22;
  assign m7     = (msum >= 9'd451);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      base8 <= 8'(h7) + 8'(l7) + 8'd114 - (m7 ? 8'd7 : 8'd0);
      leap8 <= leap7;
    end
  end

  // Stage 9: day of year; March and April both reduce to base - 34 + leap
  logic [7:0] doy_full;
  assign doy_full = base8 - 8'd34 + 8'(leap8);

  always_ff @(posedge clk) begin
    if (en[8]) begin
      out_date.doy  <= doy_full[6:0];
      out_date.leap <= leap8;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ehd_emit.sv =====
// Result sequencer: turns one Easter date into five dated holiday results.
`default_nettype none

module ehd_emit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_take,
  input  wire ehd_pkg::easter_t  in_date,
  output logic                   strobe,
  output logic [2:0]             holiday,
  output logic [4:0]             day_of_month,
  output logic [2:0]             month_number,
  output logic                   last
);
  import ehd_pkg::*;

  logic       active;
  logic [2:0] cnt;
  easter_t    cur;

  // Ready for a new date when idle or on the final result of this one
  assign in_take = !active || (cnt == HOL_ASCENSION);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= HOL_EASTER;
    end else if (in_take && in_valid) begin
      active <= 1'b1;
      cnt    <= HOL_EASTER;
    end else if (active) begin
      if (cnt == HOL_ASCENSION) begin
        active <= 1'b0;
        cnt    <= HOL_EASTER;
      end else begin
        cnt <= cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && in_valid) cur <= in_date;
  end

  // Shifted day of year, clamped at the start of the year
  logic signed [8:0] rest_s;
  logic [7:0]        rest;
  logic [8:0]        feb_end, mar_end, apr_end, may_end;
  logic [7:0]        day0;
  logic [2:0]        mon;

  always_comb begin
    rest_s  = $signed({2'b00, cur.doy}) + 9'(hol_shift(cnt));
    rest    = rest_s[8] ? 8'd0 : rest_s[7:0];
    feb_end = 9'd59 + 9'(cur.leap);
    mar_end = 9'd90 + 9'(cur.leap);
    apr_end = 9'd120 + 9'(cur.leap);
    may_end = 9'd151 + 9'(cur.leap);
    // Month walk; a date on a month's last day stays in that month
    priority if (9'(rest) < 9'd31) begin
      mon  = 3'd1;
      day0 = rest;
    end else if (9'(rest) < feb_end) begin
      mon  = 3'd2;
      day0 = rest - 8'd31;
    end else if (9'(rest) < mar_end) begin
      mon  = 3'd3;
      day0 = rest - feb_end[7:0];
    end else if (9'(rest) < apr_end) begin
      mon  = 3'd4;
      day0 = rest - mar_end[7:0];
    end else if (9'(rest) < may_end) begin
      mon  = 3'd5;
      day0 = rest - apr_end[7:0];
    end else begin
      mon  = 3'd6;
      day0 = rest - may_end[7:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= active;
    end
  end

  always_ff @(posedge clk) begin
    holiday      <= cnt;
    day_of_month <= day0[4:0] + 5'd1;
    month_number <= mon;
    last         <= active && (cnt == HOL_ASCENSION);
  end

endmodule

`default_nettype wire

// ===== sv/easter_holy_day_dates.sv =====
// Top level: Easter and related holy-day dates for a Gregorian year.
`default_nettype none

// A year is taken at a clock edge with start high and busy low. The block then
// puts out five results on consecutive cycles, each marked by strobe for one
// cycle: Easter, Carnival, Good Friday, Whitsuntide and Ascension, with last
// set on the fifth. The receiver cannot hold results off. The single result
// port, with five results per year, limits throughput; the sequencer takes
// the next date with the final result of the current one. A nine-stage computus
// pipeline feeds it, and busy rises when that pipeline is full behind it.
module easter_holy_day_dates (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] year,
  output logic             strobe,
  output logic [2:0]       holiday,
  output logic [4:0]       day_of_month,
  output logic [2:0]       month_number,
  output logic             last
);
  import ehd_pkg::*;

  logic    date_valid;
  logic    date_take;
  easter_t date;

  ehd_computus u_computus (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .year      (year),
    .busy      (busy),
    .out_valid (date_valid),
    .out_take  (date_take),
    .out_date  (date)
  );

  ehd_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (date_valid),
    .in_take      (date_take),
    .in_date      (date),
    .strobe       (strobe),
    .holiday      (holiday),
    .day_of_month (day_of_month),
    .month_number (month_number),
    .last         (last)
  );

  // No results right after reset
  a_quiet_after_reset: assert property (@(posedge clk) rst |=> !strobe)
    else $error("strobe high right after reset");

  // last marks the Ascension transfer only
  a_last_is_final: assert property (@(posedge clk) disable iff (rst)
    last |-> (strobe && holiday == HOL_ASCENSION))
    else $error("last without final holiday");

  // Results of one year come back to back in holiday order
  a_burst_order: assert property (@(posedge clk) disable iff (rst)
    (strobe && holiday != HOL_ASCENSION) |=>
      (strobe && holiday == $past(holiday) + 3'd1))
    else $error("result burst broken or out of order");

  // Easter always falls in March or April
  a_easter_month: assert property (@(posedge clk) disable iff (rst)
    (strobe && holiday == HOL_EASTER) |-> (month_number == 3'd3 || month_number == 3'd4))
    else $error("Easter outside March and April");

endmodule

`default_nettype wire
